// ----- rtl/core/hes_pkg.sv -----
// Shared types and constants for the Heston path stepper.
// Used by hes_mul, hes_sqrt, heston_euler_path_step and the testbench; depends on nothing.
package hes_pkg;

  // Sequencer states of the top level
  typedef enum logic [2:0] {
    S_IDLE,
    S_RHO_SQ,
    S_RHO_RT,
    S_DT_RT,
    S_SV,
    S_MUL,
    S_DONE
  } hes_state_t;

  // Product schedule of one time step, in issue order
  typedef enum logic [3:0] {
    OP_DW1,
    OP_RHO_E1,
    OP_RC_E2,
    OP_DW2,
    OP_REV,
    OP_DRIFT,
    OP_SV_DW2,
    OP_DIFF,
    OP_RDT,
    OP_SV_DW1,
    OP_PRICE
  } hes_op_t;

  // Phases of the multi-cycle multiplier
  typedef enum logic [1:0] {
    MP_IDLE,
    MP_LO,
    MP_HI,
    MP_FIN
  } hes_mul_phase_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_INITIAL_PRICE,
    REG_INITIAL_VARIANCE,
    REG_RATE,
    REG_KAPPA,
    REG_THETA,
    REG_XI,
    REG_RHO,
    REG_TIME_STEP
  } hes_reg_t;

  // Multiplier request: start strobe and right shift of the product
  typedef struct packed {
    logic       start;
    logic [5:0] shift;
  } hes_mul_ctl_t;

  // Product magnitude limit, also 1.0 in Q.60
  localparam logic [63:0] MUL_LIMIT = 64'h1000_0000_0000_0000;
  localparam logic [63:0] ONE_Q60   = 64'h1000_0000_0000_0000;

  // Square root: one result bit per step
  localparam int unsigned SQRT_STEPS = 32;
  localparam logic [63:0] SQRT_TOP_BIT = 64'h4000_0000_0000_0000;

  // Product shifts
  localparam logic [5:0] SH_NONE = 6'd0;
  localparam logic [5:0] SH_DW1  = 6'd16;
  localparam logic [5:0] SH_CORR = 6'd22;
  localparam logic [5:0] SH_DW2  = 6'd24;
  localparam logic [5:0] SH_Q28  = 6'd28;
  localparam logic [5:0] SH_Q32  = 6'd32;

endpackage

// ----- rtl/core/hes_mul.sv -----
// Shared signed multiplier: (a*b) >> shift on magnitudes, toward zero, saturated.
// One 32x32 multiplier used for the low and then the high half of b; depends on hes_pkg.
module hes_mul (
  input  logic                  clk,
  input  logic                  rst,
  input  hes_pkg::hes_mul_ctl_t ctl,
  input  logic signed [32:0]    op_a,
  input  logic signed [63:0]    op_b,
  output logic                  done,
  output logic signed [63:0]    res
);

  hes_pkg::hes_mul_phase_t phase, phase_next;
  logic [31:0] a_mag;
  logic [63:0] b_mag;
  logic        neg;
  logic [5:0]  shift;
  logic [95:0] acc;

  logic [32:0] a_abs;
  logic [63:0] b_abs;
  logic [63:0] prod;
  logic [95:0] shifted;
  logic [63:0] mag;

  // operand magnitudes, partial product, shift and limit
  always_comb begin
    a_abs   = op_a[32] ? 33'(-op_a) : 33'(op_a);
    b_abs   = op_b[63] ? 64'(-op_b) : 64'(op_b);
    prod    = a_mag * ((phase == hes_pkg::MP_HI) ? b_mag[63:32] : b_mag[31:0]);
    shifted = acc >> shift;
    mag     = (shifted > {32'd0, hes_pkg::MUL_LIMIT}) ? hes_pkg::MUL_LIMIT : shifted[63:0];
  end

  // phase sequence
  always_comb begin
    case (phase)
      hes_pkg::MP_IDLE: phase_next = ctl.start ? hes_pkg::MP_LO : hes_pkg::MP_IDLE;
      hes_pkg::MP_LO:   phase_next = hes_pkg::MP_HI;
      hes_pkg::MP_HI:   phase_next = hes_pkg::MP_FIN;
      hes_pkg::MP_FIN:  phase_next = hes_pkg::MP_IDLE;
      default:          phase_next = hes_pkg::MP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= hes_pkg::MP_IDLE;
      done  <= 1'b0;
    end else begin
      phase <= phase_next;
      done  <= (phase == hes_pkg::MP_FIN);
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (phase)
      hes_pkg::MP_IDLE: begin
        if (ctl.start) begin
          a_mag <= a_abs[31:0];
          b_mag <= b_abs;
          neg   <= op_a[32] ^ op_b[63];
          shift <= ctl.shift;
        end
      end
      hes_pkg::MP_LO:  acc <= {32'd0, prod};
      hes_pkg::MP_HI:  acc <= acc + {prod, 32'd0};
      hes_pkg::MP_FIN: res <= neg ? -$signed(mag) : $signed(mag);
      default: ;
    endcase
  end

endmodule

// ----- rtl/core/hes_sqrt.sv -----
// Iterative floor square root of a 64 bit value, one result bit per cycle.
// Depends on hes_pkg.
module hes_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] x,
  output logic        done,
  output logic [31:0] root
);

  logic        busy;
  logic [4:0]  cnt;
  logic [63:0] rem;
  logic [63:0] r;
  logic [63:0] b;
  logic [63:0] trial;
  logic        fits;

  always_comb begin
    trial = r + b;
    fits  = (rem >= trial);
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'(hes_pkg::SQRT_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // digit recurrence
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= x;
      r   <= '0;
      b   <= hes_pkg::SQRT_TOP_BIT;
    end else if (busy) begin
      if (fits) begin
        rem <= rem - trial;
        r   <= (r >> 1) + b;
      end else begin
        r <= r >> 1;
      end
      b <= b >> 2;
    end
  end

  assign root = r[31:0];

endmodule

// ----- rtl/core/heston_euler_path_step.sv -----
// Heston path stepper: each request is one Euler-Maruyama step (two shocks and a
// path-start flag); one result (new price, new variance) follows per request.
// A step runs from acceptance through a square root of the variance, then eleven
// products on the single shared multiplier, then a state that posts the result
// once the output is free. Writing rho starts a derivation (a product and a square
// root) and writing time_step a square root, during which requests are stalled.
// Depends on hes_pkg, hes_mul and hes_sqrt.
module heston_euler_path_step #(
  parameter int SHOCK_WIDTH = 16,
  parameter int STATE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write_en,
  input  logic [2:0]                    cfg_index,
  input  logic [31:0]                   cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          path_start,
  input  logic signed [SHOCK_WIDTH-1:0] shock_price,
  input  logic signed [SHOCK_WIDTH-1:0] shock_indep,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [31:0]            new_price,
  output logic [31:0]                   new_variance
);

  // saturation bounds of the kept state
  localparam logic [31:0] VMAX = (STATE_WIDTH >= 32) ? 32'hFFFF_FFFF :
                                 32'((64'd1 << STATE_WIDTH) - 64'd1);
  localparam logic [31:0] PMAX = (STATE_WIDTH >= 32) ? 32'h7FFF_FFFF :
                                 32'((64'd1 << (STATE_WIDTH - 1)) - 64'd1);

  hes_pkg::hes_state_t state, state_next;
  hes_pkg::hes_op_t    op;
  logic                issued;
  logic                pend_rho;
  logic                pend_dt;

  // configuration
  logic [30:0]         cfg_initial_price;
  logic [31:0]         cfg_initial_variance;
  logic signed [31:0]  cfg_rate;
  logic [31:0]         cfg_kappa;
  logic [31:0]         cfg_theta;
  logic [31:0]         cfg_xi;
  logic signed [31:0]  cfg_rho;
  logic [31:0]         cfg_time_step;
  logic [31:0]         root_dt;
  logic [31:0]         rho_comp;

  // path state and step intermediates
  logic signed [31:0]  price;
  logic [31:0]         variance;
  logic signed [SHOCK_WIDTH-1:0] e1;
  logic signed [SHOCK_WIDTH-1:0] e2;
  logic [31:0]         sv;
  logic signed [63:0]  dw1;
  logic signed [63:0]  z2;
  logic signed [63:0]  dw2;
  logic signed [63:0]  tmp;
  logic signed [63:0]  drift;
  logic signed [63:0]  diff;
  logic signed [63:0]  grow;

  // shared units
  hes_pkg::hes_mul_ctl_t mul_ctl;
  logic signed [32:0]  op_a;
  logic signed [63:0]  op_b;
  logic                mul_done;
  logic signed [63:0]  mul_res;
  logic                sqrt_start;
  logic [63:0]         sqrt_x;
  logic                sqrt_done;
  logic [31:0]         sqrt_root;

  logic                in_take;
  logic                out_free;
  logic signed [63:0]  vn;
  logic signed [63:0]  pn;
  logic [31:0]         vn_sat;
  logic signed [31:0]  pn_sat;
  logic signed [63:0]  pmax_s;

  hes_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .ctl  (mul_ctl),
    .op_a (op_a),
    .op_b (op_b),
    .done (mul_done),
    .res  (mul_res)
  );

  hes_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sqrt_start),
    .x     (sqrt_x),
    .done  (sqrt_done),
    .root  (sqrt_root)
  );

  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      hes_pkg::S_IDLE: begin
        if (pend_rho) state_next = hes_pkg::S_RHO_SQ;
        else if (pend_dt) state_next = hes_pkg::S_DT_RT;
        else if (in_valid) state_next = hes_pkg::S_SV;
      end
      hes_pkg::S_RHO_SQ: if (mul_done) state_next = hes_pkg::S_RHO_RT;
      hes_pkg::S_RHO_RT: if (sqrt_done) state_next = hes_pkg::S_IDLE;
      hes_pkg::S_DT_RT:  if (sqrt_done) state_next = hes_pkg::S_IDLE;
      hes_pkg::S_SV:     if (sqrt_done) state_next = hes_pkg::S_MUL;
      hes_pkg::S_MUL: begin
        if (mul_done && op == hes_pkg::OP_PRICE) state_next = hes_pkg::S_DONE;
      end
      hes_pkg::S_DONE:   if (out_free) state_next = hes_pkg::S_IDLE;
      default:           state_next = hes_pkg::S_IDLE;
    endcase
  end

  // state outputs: handshake, unit starts and operand selection
  always_comb begin
    in_stall      = !(state == hes_pkg::S_IDLE && !pend_rho && !pend_dt);
    mul_ctl.start = !issued && (state == hes_pkg::S_RHO_SQ || state == hes_pkg::S_MUL);
    sqrt_start    = !issued && (state == hes_pkg::S_RHO_RT || state == hes_pkg::S_DT_RT ||
                                state == hes_pkg::S_SV);
    case (state)
      hes_pkg::S_RHO_RT: sqrt_x = hes_pkg::ONE_Q60 - $unsigned(mul_res);
      hes_pkg::S_DT_RT:  sqrt_x = {cfg_time_step, 32'd0};
      default:           sqrt_x = {4'd0, variance, 28'd0};
    endcase

    op_a          = 33'(cfg_rho);
    op_b          = 64'(cfg_rho);
    mul_ctl.shift = hes_pkg::SH_NONE;
    if (state == hes_pkg::S_MUL) begin
      case (op)
        hes_pkg::OP_DW1: begin
          op_a = $signed({1'b0, root_dt}); op_b = 64'(e1); mul_ctl.shift = hes_pkg::SH_DW1;
        end
        hes_pkg::OP_RHO_E1: begin
          op_a = 33'(cfg_rho); op_b = 64'(e1); mul_ctl.shift = hes_pkg::SH_CORR;
        end
        hes_pkg::OP_RC_E2: begin
          op_a = $signed({1'b0, rho_comp}); op_b = 64'(e2); mul_ctl.shift = hes_pkg::SH_CORR;
        end
        hes_pkg::OP_DW2: begin
          op_a = $signed({1'b0, root_dt}); op_b = z2; mul_ctl.shift = hes_pkg::SH_DW2;
        end
        hes_pkg::OP_REV: begin
          op_a = $signed({1'b0, cfg_time_step});
          op_b = $signed({32'd0, cfg_theta}) - $signed({32'd0, variance});
          mul_ctl.shift = hes_pkg::SH_Q32;
        end
        hes_pkg::OP_DRIFT: begin
          op_a = $signed({1'b0, cfg_kappa}); op_b = tmp; mul_ctl.shift = hes_pkg::SH_Q28;
        end
        hes_pkg::OP_SV_DW2: begin
          op_a = $signed({1'b0, sv}); op_b = dw2; mul_ctl.shift = hes_pkg::SH_Q28;
        end
        hes_pkg::OP_DIFF: begin
          op_a = $signed({1'b0, cfg_xi}); op_b = tmp; mul_ctl.shift = hes_pkg::SH_Q28;
        end
        hes_pkg::OP_RDT: begin
          op_a = 33'(cfg_rate); op_b = $signed({32'd0, cfg_time_step});
          mul_ctl.shift = hes_pkg::SH_Q32;
        end
        hes_pkg::OP_SV_DW1: begin
          op_a = $signed({1'b0, sv}); op_b = dw1; mul_ctl.shift = hes_pkg::SH_Q28;
        end
        hes_pkg::OP_PRICE: begin
          op_a = 33'(price); op_b = grow; mul_ctl.shift = hes_pkg::SH_Q28;
        end
        default: begin
          op_a = 33'(cfg_rho); op_b = 64'(cfg_rho); mul_ctl.shift = hes_pkg::SH_NONE;
        end
      endcase
    end
  end

  // end of step: variance clamped to 0..VMAX and price saturated
  always_comb begin
    pmax_s = $signed({32'd0, PMAX});
    vn     = $signed({32'd0, variance}) + drift + diff;
    pn     = 64'(price) + mul_res;
    if (vn < 0) vn_sat = '0;
    else if (vn > $signed({32'd0, VMAX})) vn_sat = VMAX;
    else vn_sat = vn[31:0];
    if (pn > pmax_s) pn_sat = pmax_s[31:0];
    else if (pn < -pmax_s - 64'sd1) pn_sat = 32'(-pmax_s - 64'sd1);
    else pn_sat = pn[31:0];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= hes_pkg::S_IDLE;
      op        <= hes_pkg::OP_DW1;
      issued    <= 1'b0;
      pend_rho  <= 1'b0;
      pend_dt   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (mul_ctl.start || sqrt_start) issued <= 1'b1;
      else if (mul_done || sqrt_done) issued <= 1'b0;

      if (state == hes_pkg::S_SV) op <= hes_pkg::OP_DW1;
      else if (state == hes_pkg::S_MUL && mul_done) op <= hes_pkg::hes_op_t'(op + 4'd1);

      if (cfg_write_en && cfg_index == hes_pkg::REG_RHO) pend_rho <= 1'b1;
      else if (state == hes_pkg::S_IDLE) pend_rho <= 1'b0;
      if (cfg_write_en && cfg_index == hes_pkg::REG_TIME_STEP) pend_dt <= 1'b1;
      else if (state == hes_pkg::S_IDLE && !pend_rho) pend_dt <= 1'b0;

      if (state == hes_pkg::S_DONE && out_free) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  // configuration and derived values
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_initial_price    <= '0;
      cfg_initial_variance <= '0;
      cfg_rate             <= '0;
      cfg_kappa            <= '0;
      cfg_theta            <= '0;
      cfg_xi               <= '0;
      cfg_rho              <= '0;
      cfg_time_step        <= '0;
      root_dt              <= '0;
      rho_comp             <= '0;
    end else begin
      if (cfg_write_en) begin
        case (cfg_index)
          hes_pkg::REG_INITIAL_PRICE:    cfg_initial_price    <= cfg_data[30:0];
          hes_pkg::REG_INITIAL_VARIANCE: cfg_initial_variance <= cfg_data;
          hes_pkg::REG_RATE:             cfg_rate             <= $signed(cfg_data);
          hes_pkg::REG_KAPPA:            cfg_kappa            <= cfg_data;
          hes_pkg::REG_THETA:            cfg_theta            <= cfg_data;
          hes_pkg::REG_XI:               cfg_xi               <= cfg_data;
          hes_pkg::REG_RHO:              cfg_rho              <= $signed(cfg_data);
          hes_pkg::REG_TIME_STEP:        cfg_time_step        <= cfg_data;
          default: ;
        endcase
      end
      if (state == hes_pkg::S_RHO_RT && sqrt_done) rho_comp <= sqrt_root;
      if (state == hes_pkg::S_DT_RT && sqrt_done) root_dt <= sqrt_root;
    end
  end

  // path state and step datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      price    <= '0;
      variance <= '0;
    end else begin
      if (in_take && path_start) begin
        price    <= ({1'b0, cfg_initial_price} > PMAX) ? $signed(PMAX) :
                    $signed({1'b0, cfg_initial_price});
        variance <= (cfg_initial_variance > VMAX) ? VMAX : cfg_initial_variance;
      end
      if (state == hes_pkg::S_MUL && mul_done && op == hes_pkg::OP_PRICE) begin
        price    <= pn_sat;
        variance <= vn_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      e1 <= shock_price;
      e2 <= shock_indep;
    end
    if (state == hes_pkg::S_SV && sqrt_done) sv <= sqrt_root;
    if (state == hes_pkg::S_MUL && mul_done) begin
      case (op)
        hes_pkg::OP_DW1:    dw1   <= mul_res;
        hes_pkg::OP_RHO_E1: tmp   <= mul_res;
        hes_pkg::OP_RC_E2:  z2    <= tmp + mul_res;
        hes_pkg::OP_DW2:    dw2   <= mul_res;
        hes_pkg::OP_REV:    tmp   <= mul_res;
        hes_pkg::OP_DRIFT:  drift <= mul_res;
        hes_pkg::OP_SV_DW2: tmp   <= mul_res;
        hes_pkg::OP_DIFF:   diff  <= mul_res;
        hes_pkg::OP_RDT:    tmp   <= mul_res;
        hes_pkg::OP_SV_DW1: grow  <= tmp + mul_res;
        default: ;
      endcase
    end
    if (state == hes_pkg::S_DONE && out_free) begin
      new_price    <= price;
      new_variance <= variance;
    end
  end

`ifndef NO_ASSERTIONS
  // posted variance stays within the state bound
  a_var_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> new_variance <= VMAX)
    else $error("variance above bound");

  // posted price stays within the state bounds
  a_price_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ($signed(new_price) <= $signed({1'b0, PMAX}) &&
                   $signed(new_price) >= -$signed({1'b0, PMAX}) - 33'sd1))
    else $error("price out of bounds");

  // an accepted request starts with the variance root
  a_take_sv: assert property (@(posedge clk) disable iff (rst)
    in_take |=> state == hes_pkg::S_SV)
    else $error("request not started");

  // multiplier results only arrive where they are used
  a_mul_where: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> (state == hes_pkg::S_MUL || state == hes_pkg::S_RHO_SQ))
    else $error("stray multiplier result");

  // never two units started together
  a_one_start: assert property (@(posedge clk) disable iff (rst)
    !(mul_ctl.start && sqrt_start))
    else $error("two units started");
`endif

endmodule

// ----- sim/tb_heston_euler_path_step.sv -----
// Self-checking testbench for heston_euler_path_step: random Heston paths
// under several register settings, checked against an in-bench predictor.
// Depends on hes_pkg and the heston_euler_path_step RTL.
`timescale 1ns / 1ps

module tb_heston_euler_path_step;

  localparam int          NUM_STEPS   = 1950;
  localparam int          STALL_LIMIT = 20000;
  localparam int          DRAIN_WAIT  = 150;
  localparam logic [63:0] PROD_SAT    = 64'h1000_0000_0000_0000;
  localparam longint      VAR_MAX     = 64'h0000_0000_FFFF_FFFF;
  localparam longint      PRICE_MAX   = 64'h0000_0000_7FFF_FFFF;

  typedef struct {
    logic signed [31:0] price;
    logic [31:0]        variance;
  } step_result_t;

  // Heston step predictor and queue of expected results
  class heston_scoreboard;
    longint         init_price, init_var, rate, kappa, theta, xi, rho, dt;
    longint         price_now, var_now, root_dt, rho_comp;
    step_result_t   expected_q[$];
    int             mismatches;

    function new();
      init_price = 0; init_var = 0; rate = 0; kappa = 0; theta = 0; xi = 0;
      rho = 0; dt = 0; price_now = 0; var_now = 0; root_dt = 0; rho_comp = 0;
      mismatches = 0;
    endfunction

    // Integer square root, rounded down
    function longint isqrt(logic [63:0] x);
      logic [63:0] r, b;
      r = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > x) b = b >> 2;
      while (b != 0) begin
        if (x >= r + b) begin
          x = x - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return longint'(r);
    endfunction

    // Exact product, magnitude shifted toward zero, saturated to 2^60
    function longint scaled_mul(longint a, longint b, int sh);
      logic         neg;
      logic [63:0]  ua, ub;
      logic [127:0] p;
      neg = (a < 0) != (b < 0);
      ua  = (a < 0) ? 64'(-a) : 64'(a);
      ub  = (b < 0) ? 64'(-b) : 64'(b);
      p   = {64'b0, ua} * {64'b0, ub};
      p   = p >> sh;
      if (p > {64'b0, PROD_SAT}) p = {64'b0, PROD_SAT};
      return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
    endfunction

    function void write_reg(hes_pkg::hes_reg_t idx, logic [31:0] data);
      logic [63:0] mag, sq;
      case (idx)
        hes_pkg::REG_INITIAL_PRICE:    init_price = longint'(data[30:0]);
        hes_pkg::REG_INITIAL_VARIANCE: init_var   = longint'(data);
        hes_pkg::REG_RATE:             rate       = longint'(signed'(data));
        hes_pkg::REG_KAPPA:            kappa      = longint'(data);
        hes_pkg::REG_THETA:            theta      = longint'(data);
        hes_pkg::REG_XI:               xi         = longint'(data);
        hes_pkg::REG_RHO: begin
          rho      = longint'(signed'(data));
          mag      = (rho < 0) ? 64'(-rho) : 64'(rho);
          sq       = mag * mag;
          rho_comp = (sq > PROD_SAT) ? 0 : isqrt(PROD_SAT - sq);
        end
        hes_pkg::REG_TIME_STEP: begin
          dt      = longint'(data);
          root_dt = isqrt(64'(dt) << 32);
        end
        default: ;
      endcase
    endfunction

    // Note an accepted request and queue the step it must produce
    function void note_request(logic start, logic signed [15:0] sp, logic signed [15:0] si);
      longint e1, e2, v, sv, dw1, z2, dw2, drift, diff, vn, grow, pn;
      step_result_t r;
      if (start) begin
        price_now = init_price;
        var_now   = init_var;
      end
      e1    = longint'(sp);
      e2    = longint'(si);
      v     = var_now;
      sv    = isqrt(64'(var_now) << 28);
      dw1   = scaled_mul(root_dt, e1, 16);
      z2    = scaled_mul(rho, e1, 22) + scaled_mul(rho_comp, e2, 22);
      dw2   = scaled_mul(root_dt, z2, 24);
      drift = scaled_mul(kappa, scaled_mul(theta - v, dt, 32), 28);
      diff  = scaled_mul(xi, scaled_mul(sv, dw2, 28), 28);
      vn    = v + drift + diff;
      if (vn < 0) vn = 0;
      if (vn > VAR_MAX) vn = VAR_MAX;
      grow  = scaled_mul(rate, dt, 32) + scaled_mul(sv, dw1, 28);
      pn    = price_now + scaled_mul(price_now, grow, 28);
      if (pn > PRICE_MAX) pn = PRICE_MAX;
      if (pn < -PRICE_MAX - 1) pn = -PRICE_MAX - 1;
      price_now  = pn;
      var_now    = vn;
      r.price    = pn[31:0];
      r.variance = vn[31:0];
      expected_q.push_back(r);
    endfunction

    function void check_result(logic signed [31:0] price, logic [31:0] variance);
      step_result_t e;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result price=%0d variance=%0d", price, variance);
        return;
      end
      e = expected_q.pop_front();
      if (e.price !== price || e.variance !== variance) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: price exp %0d got %0d, variance exp %0d got %0d",
                   e.price, price, e.variance, variance);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                     clk, rst;
  logic                     cfg_write_en;
  logic [2:0]               cfg_index;
  logic [31:0]              cfg_data;
  logic                     in_valid, in_stall;
  logic                     path_start;
  logic signed [15:0]       shock_price, shock_indep;
  logic                     out_valid, out_stall;
  logic signed [31:0]       new_price;
  logic [31:0]              new_variance;

  heston_scoreboard sb;
  int               steps_sent;
  int               burst_left;
  int               idle_cycles = 0;
  int               stall_mode = 0, stall_left = 0;

  heston_euler_path_step DUT (
    .clk(clk), .rst(rst),
    .cfg_write_en(cfg_write_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .path_start(path_start), .shock_price(shock_price), .shock_indep(shock_indep),
    .out_valid(out_valid), .out_stall(out_stall),
    .new_price(new_price), .new_variance(new_variance)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Request sender: valid stays high after acceptance until the next call or a pause
  task automatic send_step(logic start, logic signed [15:0] sp, logic signed [15:0] si);
    int gap;
    @(negedge clk);
    in_valid    = 1'b1;
    path_start  = start;
    shock_price = sp;
    shock_indep = si;
    do @(posedge clk); while (in_stall);
    sb.note_request(start, sp, si);
    steps_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 120);
      if (gap > 0) begin
        @(negedge clk);
        in_valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  task automatic go_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(hes_pkg::hes_reg_t idx, logic [31:0] data);
    @(negedge clk);
    cfg_write_en = 1'b1;
    cfg_index    = idx;
    cfg_data     = data;
    @(posedge clk);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_write_en = 1'b0;
  endtask

  // Register settings: 0 plausible market, 1 anything in range, 2 extremes
  task automatic configure(int mode);
    logic [31:0] rv;
    for (int i = 0; i < 8; i++) begin
      case (mode)
        0: case (hes_pkg::hes_reg_t'(i))
             hes_pkg::REG_INITIAL_PRICE:    rv = $urandom_range(1, 500) << 16;
             hes_pkg::REG_INITIAL_VARIANCE: rv = $urandom_range(0, 32'h0400_0000);
             hes_pkg::REG_RATE:
               rv = $urandom_range(0, 32'h0200_0000) - 32'h0080_0000;
             hes_pkg::REG_KAPPA:            rv = $urandom_range(0, 32'h4000_0000);
             hes_pkg::REG_THETA:            rv = $urandom_range(0, 32'h0400_0000);
             hes_pkg::REG_XI:               rv = $urandom_range(0, 32'h1000_0000);
             hes_pkg::REG_RHO:
               rv = $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
             default:                       rv = 32'hFFFF_FFFF / $urandom_range(12, 365);
           endcase
        1: begin
          rv = $urandom;
          if (hes_pkg::hes_reg_t'(i) == hes_pkg::REG_RHO)
            rv = $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
          if (hes_pkg::hes_reg_t'(i) == hes_pkg::REG_INITIAL_PRICE) rv[31] = 1'b0;
        end
        default: begin
          rv = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
          if (hes_pkg::hes_reg_t'(i) == hes_pkg::REG_INITIAL_PRICE)
            rv = rv ? 32'h7FFF_FFFF : 32'h0;
          if (hes_pkg::hes_reg_t'(i) == hes_pkg::REG_RATE)
            rv = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
          if (hes_pkg::hes_reg_t'(i) == hes_pkg::REG_RHO)
            rv = $urandom_range(0, 1) ? 32'h4000_0000 : 32'hC000_0000;
        end
      endcase
      write_reg(hes_pkg::hes_reg_t'(i), rv);
    end
  endtask

  function automatic logic [15:0] draw_shock();
    if ($urandom_range(0, 5) == 0) return 16'($urandom);
    return 16'($urandom_range(0, 16384) - 8192);
  endfunction

  // Receiver stall pattern: free runs, random stalls and long holds
  always @(negedge clk) begin
    if (rst) begin
      out_stall = 1'b0;
    end else begin
      if (stall_left <= 0) begin
        stall_mode = $urandom_range(0, 2);
        stall_left = $urandom_range(20, 600);
      end
      stall_left--;
      case (stall_mode)
        0:       out_stall = 1'b0;
        1:       out_stall = $urandom_range(0, 1);
        default: out_stall = ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  // Result checking
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(new_price, new_variance);
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    int path_len;
    sb           = new();
    rst          = 1'b1;
    cfg_write_en = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    in_valid     = 1'b0;
    path_start   = 1'b0;
    shock_price  = '0;
    shock_indep  = '0;
    steps_sent   = 0;
    burst_left   = 1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: reset settings, then shock extremes on a plausible path
    send_step(1'b1, 16'sh7FFF, 16'sh8000);
    send_step(1'b0, 16'sh0000, 16'sh0000);
    go_idle();
    configure(0);
    send_step(1'b1, 16'sh7FFF, 16'sh7FFF);
    send_step(1'b0, 16'sh8000, 16'sh8000);
    send_step(1'b0, 16'sh8000, 16'sh7FFF);
    send_step(1'b0, 16'sh0000, 16'shFFFF);
    for (int i = 0; i < 6; i++) send_step(1'b0, 16'sh8000, 16'sh8000);
    send_step(1'b1, 16'sh1000, 16'shF000);
    go_idle();
    // Correlation beyond one and zero variance start
    write_reg(hes_pkg::REG_RHO, 32'h7FFF_FFFF);
    write_reg(hes_pkg::REG_INITIAL_VARIANCE, 32'h0);
    send_step(1'b1, 16'sh7FFF, 16'sh7FFF);
    send_step(1'b0, 16'sh8000, 16'sh0000);
    go_idle();
    configure(2);
    for (int i = 0; i < 6; i++) send_step(i == 0, draw_shock(), draw_shock());
    send_step(1'b0, 16'sh7FFF, 16'sh8000);

    // Random phases of well-formed paths with some noise
    while (steps_sent < NUM_STEPS) begin
      go_idle();
      configure(($urandom_range(0, 9) < 6) ? 0 : $urandom_range(1, 2));
      for (int p = 0; p < 12 && steps_sent < NUM_STEPS; p++) begin
        path_len = $urandom_range(1, 40);
        for (int k = 0; k < path_len; k++) begin
          if ($urandom_range(0, 19) == 0)
            send_step(1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom));
          else
            send_step(k == 0, draw_shock(), draw_shock());
        end
      end
    end

    go_idle();
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- heston_euler_path_step.f -----
rtl/core/hes_pkg.sv
rtl/core/hes_mul.sv
rtl/core/hes_sqrt.sv
rtl/core/heston_euler_path_step.sv
sim/tb_heston_euler_path_step.sv
